// ===== rtl/kbpi_pkg.sv =====
`timescale 1ns / 1ps
package kbpi_pkg;

  // Datapath width of the rotator and the divisor.
  localparam int CW = 34;
  // Dividend and quotient width of the divider.
  localparam int DW = 64;
  localparam int ATAN_N = 24;

  typedef logic signed [CW-1:0] cdata_t;

  typedef struct packed {
    cdata_t x;
    cdata_t y;
    cdata_t z;
  } cordic_req_t;

  localparam logic [1:0] FUNC_START = 2'd0;
  localparam logic [1:0] FUNC_CTRL  = 2'd1;
  localparam logic [1:0] FUNC_TICK  = 2'd2;

  // Address of the wheelbase register.
  localparam logic [1:0] ADDR_WHEELBASE = 2'd0;

  localparam logic signed [14:0] STEER_LIMIT = 15'sd14564;
  localparam cdata_t INV_GAIN = 34'sh026DD3B6A;
  localparam cdata_t UNIT_Q30 = 34'sh040000000;
  localparam logic signed [22:0] RAD_TO_BAM = 23'sd2670177;
  localparam logic [15:0] WB_RESET = 16'd691;

  // Arctangent of 2^-i in units of 2^32 per turn.
  function automatic cdata_t atan_entry(input logic [4:0] i);
    cdata_t r;
    case (i)
      5'd0:  r = 34'sh020000000;
      5'd1:  r = 34'sh012E4051E;
      5'd2:  r = 34'sh009FB385B;
      5'd3:  r = 34'sh0051111D4;
      5'd4:  r = 34'sh0028B0D43;
      5'd5:  r = 34'sh00145D7E1;
      5'd6:  r = 34'sh000A2F61E;
      5'd7:  r = 34'sh000517C55;
      5'd8:  r = 34'sh00028BE53;
      5'd9:  r = 34'sh000145F2F;
      5'd10: r = 34'sh0000A2F98;
      5'd11: r = 34'sh0000517CC;
      5'd12: r = 34'sh000028BE6;
      5'd13: r = 34'sh0000145F3;
      5'd14: r = 34'sh00000A2FA;
      5'd15: r = 34'sh00000517D;
      5'd16: r = 34'sh0000028BE;
      5'd17: r = 34'sh00000145F;
      5'd18: r = 34'sh000000A30;
      5'd19: r = 34'sh000000518;
      5'd20: r = 34'sh00000028C;
      5'd21: r = 34'sh000000146;
      5'd22: r = 34'sh0000000A3;
      5'd23: r = 34'sh000000051;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/kbpi_cordic.sv =====
`timescale 1ns / 1ps
module kbpi_cordic #(
  parameter int ITER = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  kbpi_pkg::cordic_req_t req,
  output logic                 done,
  output kbpi_pkg::cdata_t     x_out,
  output kbpi_pkg::cdata_t     y_out
);
  import kbpi_pkg::*;

  localparam int NI = (ITER < ATAN_N) ? ITER : ATAN_N;
  localparam int IW = $clog2(NI + 1);

  cdata_t x_r, y_r, z_r;
  cdata_t x_nxt, y_nxt, z_nxt;
  cdata_t xs, ys, at;
  logic [IW-1:0] cnt_r;
  logic run_r, done_r;

  // One micro-rotation per cycle, direction from the sign of the residual angle.
  always_comb begin
    xs = x_r >>> cnt_r;
    ys = y_r >>> cnt_r;
    at = atan_entry(5'(cnt_r));
    if (!z_r[CW-1]) begin
      x_nxt = x_r - ys;
      y_nxt = y_r + xs;
      z_nxt = z_r - at;
    end else begin
      x_nxt = x_r + ys;
      y_nxt = y_r - xs;
      z_nxt = z_r + at;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        x_r   <= req.x;
        y_r   <= req.y;
        z_r   <= req.z;
        cnt_r <= '0;
        run_r <= 1'b1;
      end else if (run_r) begin
        x_r   <= x_nxt;
        y_r   <= y_nxt;
        z_r   <= z_nxt;
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == IW'(NI - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done  = done_r;
  assign x_out = x_r;
  assign y_out = y_r;

endmodule

// ===== rtl/kbpi_div.sv =====
`timescale 1ns / 1ps
module kbpi_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [kbpi_pkg::DW-1:0]         dividend,
  input  logic [kbpi_pkg::CW-1:0]         divisor,
  output logic                            done,
  output logic [kbpi_pkg::DW-1:0]         quot
);
  import kbpi_pkg::*;

  localparam int NW = $clog2(DW + 1);

  logic [CW-1:0] rem_r, dvs_r;
  logic [DW-1:0] q_r;
  logic [CW:0]   trial;
  logic          ge;
  logic [NW-1:0] cnt_r;
  logic          run_r, done_r;

  // Restoring division, one quotient bit per cycle, MSB first.
  always_comb begin
    trial = {rem_r, q_r[DW-1]};
    ge    = (trial >= {1'b0, dvs_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        rem_r <= '0;
        q_r   <= dividend;
        dvs_r <= divisor;
        cnt_r <= '0;
        run_r <= 1'b1;
      end else if (run_r) begin
        rem_r <= ge ? CW'(trial - {1'b0, dvs_r}) : trial[CW-1:0];
        q_r   <= {q_r[DW-2:0], ge};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == NW'(DW - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

// ===== rtl/kinematic_bicycle_pose_integrator.sv =====
`timescale 1ns / 1ps
// Start, control and unused items pass to S_DONE, which raises out_valid.
// A tick item raises out_valid only after two passes of the shared
// CORDIC rotator and two passes of the divider.
// Throughput: one item at a time; a new transfer is taken once the result has been taken.
// Reset (synchronous, rst_n low) clears pose, speed and steer and sets wheelbase to 691.
module kinematic_bicycle_pose_integrator #(
  parameter int TRIG_ITERATIONS = 16,
  parameter int POSITION_WIDTH  = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_func,
  input  logic signed [31:0] in_start_x_in,
  input  logic signed [31:0] in_start_y_in,
  input  logic [15:0]        in_start_heading_in,
  input  logic signed [15:0] in_speed_in,
  input  logic signed [14:0] in_steer_in,
  input  logic [15:0]        in_dt_in,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_pos_x_out,
  output logic signed [31:0] out_pos_y_out,
  output logic [15:0]        out_heading_out,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [1:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import kbpi_pkg::*;

  localparam int PW = POSITION_WIDTH;
  // Sum width: room for the position plus a 33-bit step without overflow.
  localparam int SW = ((PW > 32) ? PW : 32) + 2;

  typedef enum logic [3:0] {
    S_IDLE, S_SC_GO, S_SC_W, S_TN_GO, S_TN_W, S_TD_GO, S_TD_W,
    S_M1, S_M2, S_M3, S_M4, S_WD_GO, S_WD_W, S_M5, S_UPD, S_DONE
  } state_t;

  state_t state_r;

  logic [15:0]          wheelbase_r;
  logic signed [PW-1:0] pos_x_r, pos_y_r;
  logic [15:0]          heading_r;
  logic signed [15:0]   speed_r;
  logic signed [14:0]   steer_r;
  logic [15:0]          dt_r;

  logic                 fold_neg_r;
  cdata_t               c_r, s_r, tx_r, ty_r;
  logic signed [31:0]   tan_r;
  logic signed [32:0]   svdt_r;
  logic signed [47:0]   sptan_r;
  logic signed [66:0]   prod_r;
  logic signed [32:0]   dx_r, dy_r;
  logic signed [63:0]   num_r, omega_r;
  logic [15:0]          hstep_r;

  logic                 out_valid_r;
  logic signed [31:0]   out_x_r, out_y_r;
  logic [15:0]          out_h_r;

  // Shared units.
  logic        cordic_start, cordic_done;
  cordic_req_t cordic_req;
  cdata_t      cx, cy;
  logic        div_start, div_done;
  logic [DW-1:0] div_dividend, div_quot;
  logic [CW-1:0] div_divisor;

  kbpi_cordic #(.ITER(TRIG_ITERATIONS)) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cordic_start),
    .req   (cordic_req),
    .done  (cordic_done),
    .x_out (cx),
    .y_out (cy)
  );

  kbpi_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quot     (div_quot)
  );

  // Heading folded into plus or minus a quarter turn; the half-turn flip
  // negates both sine and cosine afterwards.
  logic signed [16:0] fold_a;
  logic               fold_neg;
  always_comb begin
    fold_a   = $signed({heading_r[15], heading_r});
    fold_neg = 1'b0;
    if (fold_a > 17'sd16384) begin
      fold_a   = fold_a - 17'sd32768;
      fold_neg = 1'b1;
    end else if (fold_a < -17'sd16384) begin
      fold_a   = fold_a + 17'sd32768;
      fold_neg = 1'b1;
    end
  end

  logic   ty_neg, num_neg;
  cdata_t ty_mag;
  logic [63:0] num_mag;
  logic [CW-1:0] wb_eff;
  always_comb begin
    cordic_start = (state_r == S_SC_GO) || (state_r == S_TN_GO);
    if (state_r == S_SC_GO) begin
      cordic_req.x = INV_GAIN;
      cordic_req.y = '0;
      cordic_req.z = cdata_t'(fold_a) <<< 16;
    end else begin
      cordic_req.x = UNIT_Q30;
      cordic_req.y = '0;
      cordic_req.z = cdata_t'(steer_r) <<< 16;
    end

    ty_neg  = ty_r[CW-1];
    ty_mag  = ty_neg ? -ty_r : ty_r;
    num_neg = num_r[63];
    num_mag = num_neg ? 64'(-num_r) : 64'(num_r);
    // A zero wheelbase counts as the smallest step.
    wb_eff  = (wheelbase_r == 16'd0) ? CW'(1) : CW'(wheelbase_r);

    div_start = (state_r == S_TD_GO) || (state_r == S_WD_GO);
    if (state_r == S_TD_GO) begin
      div_dividend = DW'(ty_mag) << 16;
      div_divisor  = tx_r;
    end else begin
      div_dividend = num_mag;
      div_divisor  = wb_eff;
    end
  end

  // Saturation of the wide sums and the start values to the position range, and the steering clamp.
  logic signed [SW-1:0] pmax, pmin;
  logic signed [SW-1:0] sum_x, sum_y, st_x, st_y;
  logic signed [PW-1:0] sat_x, sat_y, sat_sx, sat_sy;
  logic signed [14:0]   steer_clamped;
  always_comb begin
    pmax  = {{(SW-PW+1){1'b0}}, {(PW-1){1'b1}}};
    pmin  = ~pmax;
    sum_x = SW'(pos_x_r) + SW'(dx_r);
    sum_y = SW'(pos_y_r) + SW'(dy_r);
    st_x  = SW'(in_start_x_in);
    st_y  = SW'(in_start_y_in);
    sat_x  = (sum_x > pmax) ? pmax[PW-1:0] : (sum_x < pmin) ? pmin[PW-1:0] : sum_x[PW-1:0];
    sat_y  = (sum_y > pmax) ? pmax[PW-1:0] : (sum_y < pmin) ? pmin[PW-1:0] : sum_y[PW-1:0];
    sat_sx = (st_x > pmax) ? pmax[PW-1:0] : (st_x < pmin) ? pmin[PW-1:0] : st_x[PW-1:0];
    sat_sy = (st_y > pmax) ? pmax[PW-1:0] : (st_y < pmin) ? pmin[PW-1:0] : st_y[PW-1:0];
    if (in_steer_in > STEER_LIMIT) begin
      steer_clamped = STEER_LIMIT;
    end else if (in_steer_in < -STEER_LIMIT) begin
      steer_clamped = -STEER_LIMIT;
    end else begin
      steer_clamped = in_steer_in;
    end
  end

  logic signed [SW-1:0] wide_x, wide_y;
  logic [67:0]          hprod;
  logic signed [66:0]   prod_rnd;
  logic signed [70:0]   num_full;
  always_comb begin
    wide_x   = SW'(pos_x_r);
    wide_y   = SW'(pos_y_r);
    prod_rnd = prod_r + (67'sd1 <<< 33);
    num_full = 71'(sptan_r) * 71'(RAD_TO_BAM);
    hprod    = 68'(omega_r[51:0]) * 68'(dt_r) + (68'd1 << 35);
  end

  // Sequencer: the tick walks through sine and cosine, tangent, tangent
  // division, the products, the rate division and the pose update.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      wheelbase_r <= WB_RESET;
      pos_x_r     <= '0;
      pos_y_r     <= '0;
      heading_r   <= '0;
      speed_r     <= '0;
      steer_r     <= '0;
    end else begin
      if (psel && penable && pwrite && (paddr == ADDR_WHEELBASE)) begin
        wheelbase_r <= pwdata[15:0];
      end
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            dt_r <= in_dt_in;
            case (in_func)
              FUNC_START: begin
                pos_x_r   <= sat_sx;
                pos_y_r   <= sat_sy;
                heading_r <= in_start_heading_in;
                speed_r   <= '0;
                steer_r   <= '0;
                state_r   <= S_DONE;
              end
              FUNC_CTRL: begin
                speed_r <= in_speed_in;
                steer_r <= steer_clamped;
                state_r <= S_DONE;
              end
              FUNC_TICK: state_r <= S_SC_GO;
              default:   state_r <= S_DONE;
            endcase
          end
        end
        S_SC_GO: begin
          fold_neg_r <= fold_neg;
          state_r    <= S_SC_W;
        end
        S_SC_W: begin
          if (cordic_done) begin
            c_r     <= fold_neg_r ? -cx : cx;
            s_r     <= fold_neg_r ? -cy : cy;
            state_r <= S_TN_GO;
          end
        end
        S_TN_GO: state_r <= S_TN_W;
        S_TN_W: begin
          if (cordic_done) begin
            tx_r    <= (cx < cdata_t'(1)) ? cdata_t'(1) : cx;
            ty_r    <= cy;
            state_r <= S_TD_GO;
          end
        end
        S_TD_GO: state_r <= S_TD_W;
        S_TD_W: begin
          if (div_done) begin
            tan_r   <= ty_neg ? -$signed(div_quot[31:0]) : $signed(div_quot[31:0]);
            state_r <= S_M1;
          end
        end
        S_M1: begin
          svdt_r  <= 33'(speed_r) * $signed({17'd0, dt_r});
          sptan_r <= 48'(speed_r) * 48'(tan_r);
          state_r <= S_M2;
        end
        S_M2: begin
          prod_r  <= 67'(svdt_r) * 67'(c_r);
          state_r <= S_M3;
        end
        S_M3: begin
          dx_r    <= prod_rnd[66:34];
          prod_r  <= 67'(svdt_r) * 67'(s_r);
          state_r <= S_M4;
        end
        S_M4: begin
          dy_r    <= prod_rnd[66:34];
          num_r   <= num_full[63:0];
          state_r <= S_WD_GO;
        end
        S_WD_GO: state_r <= S_WD_W;
        S_WD_W: begin
          if (div_done) begin
            omega_r <= num_neg ? -$signed(div_quot) : $signed(div_quot);
            state_r <= S_M5;
          end
        end
        S_M5: begin
          hstep_r <= hprod[51:36];
          state_r <= S_UPD;
        end
        S_UPD: begin
          pos_x_r   <= sat_x;
          pos_y_r   <= sat_y;
          heading_r <= heading_r + hstep_r;
          state_r   <= S_DONE;
        end
        S_DONE: begin
          out_x_r     <= wide_x[31:0];
          out_y_r     <= wide_y[31:0];
          out_h_r     <= heading_r;
          out_valid_r <= 1'b1;
          state_r     <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready        = (state_r == S_IDLE) && !out_valid_r;
  assign out_valid       = out_valid_r;
  assign out_pos_x_out   = out_x_r;
  assign out_pos_y_out   = out_y_r;
  assign out_heading_out = out_h_r;
  assign prdata          = {16'd0, wheelbase_r};
  assign pready          = 1'b1;

  // The block leaves idle after every transfer and is not ready in the following cycle.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second transfer taken while an item is in flight");

  // No result may be pending while an item is being worked on.
  a_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !out_valid_r)
    else $error("result pending during work");

  // The latched steering angle always lies inside the limit.
  a_steer_lim: assert property (@(posedge clk) disable iff (!rst_n)
    (steer_r <= STEER_LIMIT) && (steer_r >= -STEER_LIMIT))
    else $error("steer latch outside limit");

  // The rotator finishes only while the sequencer waits for it.
  a_cordic_wait: assert property (@(posedge clk) disable iff (!rst_n)
    cordic_done |-> (state_r == S_SC_W) || (state_r == S_TN_W))
    else $error("rotator finished outside a wait state");

endmodule

// ===== bench/kinematic_bicycle_pose_integrator_tb.sv =====
`timescale 1ns / 1ps
module kinematic_bicycle_pose_integrator_tb;
  import kbpi_pkg::*;

  // One input item as it is presented on the input channel.
  typedef struct {
    logic [1:0]         func;
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic [15:0]        sh;
    logic signed [15:0] spd;
    logic signed [14:0] str;
    logic [15:0]        dt;
  } motion_cmd_t;

  // One pose as returned on the result channel.
  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic [15:0]        h;
  } pose_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [1:0]         in_func;
  logic signed [31:0] in_start_x_in;
  logic signed [31:0] in_start_y_in;
  logic [15:0]        in_start_heading_in;
  logic signed [15:0] in_speed_in;
  logic signed [14:0] in_steer_in;
  logic [15:0]        in_dt_in;
  logic               out_valid;
  logic               out_ready;
  logic signed [31:0] out_pos_x_out;
  logic signed [31:0] out_pos_y_out;
  logic [15:0]        out_heading_out;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [1:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  kinematic_bicycle_pose_integrator u_top (.*);

  // Register index of the wheelbase in the configuration space.
  localparam logic [1:0] REG_WHEELBASE = 2'd0;

  // Mirror of the block's state, updated as each transfer is accepted.
  longint     mdl_x, mdl_y;
  logic [15:0] mdl_heading;
  longint     mdl_speed, mdl_steer;
  longint     mdl_wheelbase;

  motion_cmd_t cmd_backlog[$];
  pose_t       pose_expected[$];
  motion_cmd_t cur_cmd;
  int          send_gap, recv_stall;
  bit          no_idle;
  int          errors;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    errors++;
  endtask

  function automatic longint atan_step(input int i);
    case (i)
      0:  return 64'h20000000;
      1:  return 64'h12E4051E;
      2:  return 64'h09FB385B;
      3:  return 64'h051111D4;
      4:  return 64'h028B0D43;
      5:  return 64'h0145D7E1;
      6:  return 64'h00A2F61E;
      7:  return 64'h00517C55;
      8:  return 64'h0028BE53;
      9:  return 64'h00145F2F;
      10: return 64'h000A2F98;
      11: return 64'h000517CC;
      12: return 64'h00028BE6;
      13: return 64'h000145F3;
      14: return 64'h0000A2FA;
      default: return 64'h0000517D;
    endcase
  endfunction

  // Vector rotation by angle z (2^32 per turn); arithmetic shifts floor.
  task automatic rotate(input longint z, inout longint x, inout longint y);
    longint xs, ys;
    for (int i = 0; i < 16; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys;
        y = y + xs;
        z = z - atan_step(i);
      end else begin
        x = x + ys;
        y = y - xs;
        z = z + atan_step(i);
      end
    end
  endtask

  function automatic longint clamp_pos(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Advance the mirrored state by one item and queue the pose it returns.
  task automatic integrate_pose(input motion_cmd_t c);
    longint a, cs, sn, tx, ty, dtl, tq, omega, wb;
    logic [63:0] prod;
    bit flip;
    pose_t p;
    case (c.func)
      FUNC_START: begin
        mdl_x = c.sx;
        mdl_y = c.sy;
        mdl_heading = c.sh;
        mdl_speed = 0;
        // A start also forgets the steering; the heading is not copied into it.
        mdl_steer = 0;
      end
      FUNC_CTRL: begin
        mdl_speed = c.spd;
        mdl_steer = c.str;
        if (mdl_steer > STEER_LIMIT) mdl_steer = STEER_LIMIT;
        if (mdl_steer < -STEER_LIMIT) mdl_steer = -STEER_LIMIT;
      end
      FUNC_TICK: begin
        // Fold the heading into +-90 degrees; the half turn flips both signs.
        a = (mdl_heading >= 16'd32768) ? longint'(mdl_heading) - 65536
                                        : longint'(mdl_heading);
        flip = 1'b0;
        if (a > 16384) begin
          a = a - 32768;
          flip = 1'b1;
        end else if (a < -16384) begin
          a = a + 32768;
          flip = 1'b1;
        end
        cs = 64'h26DD3B6A;
        sn = 0;
        rotate(a * 65536, cs, sn);
        if (flip) begin
          cs = -cs;
          sn = -sn;
        end
        dtl = c.dt;
        mdl_x = clamp_pos(mdl_x + ((mdl_speed * cs * dtl + (64'sd1 <<< 33)) >>> 34));
        mdl_y = clamp_pos(mdl_y + ((mdl_speed * sn * dtl + (64'sd1 <<< 33)) >>> 34));
        // Steering tangent in Q16, truncated toward zero.
        tx = 64'sd1 <<< 30;
        ty = 0;
        rotate(mdl_steer * 65536, tx, ty);
        if (tx < 1) tx = 1;
        tq = (ty * 65536) / tx;
        wb = (mdl_wheelbase == 0) ? 1 : mdl_wheelbase;
        omega = (mdl_speed * tq * 2670177) / wb;
        prod = 64'(omega) * 64'(dtl) + (64'd1 << 35);
        mdl_heading = mdl_heading + prod[51:36];
      end
      default: ;  // Unused code: pose is returned unchanged.
    endcase
    p.x = mdl_x[31:0];
    p.y = mdl_y[31:0];
    p.h = mdl_heading;
    pose_expected.push_back(p);
  endtask

  // Input side: one nonblocking update of valid per edge, payload held until taken.
  always @(posedge clk) begin
    logic nv;
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      nv = in_valid;
      if (in_valid && in_ready) begin
        integrate_pose(cur_cmd);
        nv = 1'b0;
      end
      if (!nv) begin
        if (send_gap != 0) begin
          send_gap <= send_gap - 1;
        end else if (cmd_backlog.size() > 0) begin
          cur_cmd = cmd_backlog.pop_front();
          in_func             <= cur_cmd.func;
          in_start_x_in       <= cur_cmd.sx;
          in_start_y_in       <= cur_cmd.sy;
          in_start_heading_in <= cur_cmd.sh;
          in_speed_in         <= cur_cmd.spd;
          in_steer_in         <= cur_cmd.str;
          in_dt_in            <= cur_cmd.dt;
          nv = 1'b1;
          send_gap <= no_idle ? 0 : $urandom_range(0, 7);
        end
      end
      in_valid <= nv;
    end
  end

  // Result side: compare each transfer with the oldest queued pose.
  always @(posedge clk) begin
    pose_t e;
    int st;
    if (!rst_n) begin
      out_ready <= 1'b0;
      recv_stall <= 0;
    end else begin
      st = recv_stall;
      if (out_valid && out_ready) begin
        if (pose_expected.size() == 0) begin
          report("pose returned with none outstanding");
        end else begin
          e = pose_expected.pop_front();
          if (out_pos_x_out !== e.x)
            report($sformatf("x got %h want %h", out_pos_x_out, e.x));
          if (out_pos_y_out !== e.y)
            report($sformatf("y got %h want %h", out_pos_y_out, e.y));
          if (out_heading_out !== e.h)
            report($sformatf("heading got %h want %h", out_heading_out, e.h));
        end
        st = no_idle ? 0 : $urandom_range(0, 7);
      end
      if (st > 0) begin
        out_ready <= 1'b0;
        recv_stall <= st - 1;
      end else begin
        out_ready <= 1'b1;
        recv_stall <= 0;
      end
    end
  end

  function automatic motion_cmd_t mk_cmd(input logic [1:0] f);
    motion_cmd_t c;
    c.func = f;
    c.sx  = ($urandom_range(0, 3) == 0) ? $urandom() : $signed($urandom_range(0, 2000000)) - 1000000;
    c.sy  = ($urandom_range(0, 3) == 0) ? $urandom() : $signed($urandom_range(0, 2000000)) - 1000000;
    c.sh  = 16'($urandom());
    c.spd = 16'($urandom());
    c.str = ($urandom_range(0, 3) == 0) ? 15'($urandom())
                                        : 15'($signed($urandom_range(0, 29128)) - 14564);
    c.dt  = ($urandom_range(0, 3) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 4096));
    return c;
  endfunction

  function automatic motion_cmd_t fixed_cmd(input logic [1:0] f, input logic [31:0] x,
                                            input logic [31:0] y, input logic [15:0] h,
                                            input logic [15:0] v, input logic [14:0] s,
                                            input logic [15:0] d);
    motion_cmd_t c;
    c.func = f; c.sx = x; c.sy = y; c.sh = h; c.spd = v; c.str = s; c.dt = d;
    return c;
  endfunction

  task automatic wait_drained();
    while (cmd_backlog.size() > 0 || in_valid || pose_expected.size() > 0)
      @(posedge clk);
    // Give the block time to finish any tick and settle fully.
    repeat (300) @(posedge clk);
  endtask

  task automatic write_wheelbase(input logic [15:0] v);
    @(posedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= REG_WHEELBASE; pwdata <= {16'd0, v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    mdl_wheelbase = v;
  endtask

  // Mostly well-formed drives: start, control, a run of ticks, then some noise.
  task automatic random_drive(input int n);
    int k;
    k = 0;
    while (k < n) begin
      cmd_backlog.push_back(mk_cmd(FUNC_START));
      cmd_backlog.push_back(mk_cmd(FUNC_CTRL));
      k += 2;
      repeat ($urandom_range(1, 8)) begin
        cmd_backlog.push_back(mk_cmd(FUNC_TICK));
        k++;
        if ($urandom_range(0, 5) == 0) begin
          cmd_backlog.push_back(mk_cmd(FUNC_CTRL));
          k++;
        end
      end
      if ($urandom_range(0, 3) == 0) begin
        cmd_backlog.push_back(mk_cmd(2'($urandom_range(0, 3))));
        k++;
      end
    end
  endtask

  initial begin
    logic [15:0] wb_plan[5];
    errors = 0;
    rst_n = 1'b0;
    in_valid = 1'b0; out_ready = 1'b0; no_idle = 1'b0;
    in_func = FUNC_START; in_start_x_in = '0; in_start_y_in = '0;
    in_start_heading_in = '0; in_speed_in = '0; in_steer_in = '0; in_dt_in = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = REG_WHEELBASE; pwdata = '0;
    mdl_x = 0; mdl_y = 0; mdl_heading = '0; mdl_speed = 0; mdl_steer = 0;
    mdl_wheelbase = WB_RESET;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part under the reset wheelbase: extremes of every field,
    // all item kinds, steering past its limit, saturation and the unused code.
    cmd_backlog.push_back(fixed_cmd(FUNC_TICK, 0, 0, 0, 0, 0, 16'hFFFF));
    cmd_backlog.push_back(fixed_cmd(FUNC_START, 32'h7FFFFFF0, 32'h80000010, 16'h0000,
                                    0, 0, 0));
    cmd_backlog.push_back(fixed_cmd(FUNC_CTRL, 0, 0, 0, 16'h7FFF, 15'sd16383, 0));
    cmd_backlog.push_back(fixed_cmd(FUNC_TICK, 0, 0, 0, 0, 0, 16'hFFFF));
    cmd_backlog.push_back(fixed_cmd(FUNC_TICK, 0, 0, 0, 0, 0, 16'h0000));
    cmd_backlog.push_back(fixed_cmd(FUNC_START, 32'h80000000, 32'h7FFFFFFF, 16'hC000,
                                    16'hFFFF, 15'h7FFF, 16'hFFFF));
    cmd_backlog.push_back(fixed_cmd(FUNC_TICK, 0, 0, 0, 0, 0, 16'h1000));
    cmd_backlog.push_back(fixed_cmd(FUNC_CTRL, 0, 0, 0, 16'h8000, -15'sd16384, 0));
    cmd_backlog.push_back(fixed_cmd(FUNC_TICK, 0, 0, 0, 0, 0, 16'hFFFF));
    cmd_backlog.push_back(fixed_cmd(FUNC_START, 0, 0, 16'h4000, 0, 0, 0));
    cmd_backlog.push_back(fixed_cmd(FUNC_CTRL, 0, 0, 0, 16'h0100, 15'sd14564, 0));
    cmd_backlog.push_back(fixed_cmd(FUNC_TICK, 0, 0, 0, 0, 0, 16'h1000));
    cmd_backlog.push_back(fixed_cmd(FUNC_START, 0, 0, 16'h8000, 0, 0, 0));
    cmd_backlog.push_back(fixed_cmd(FUNC_CTRL, 0, 0, 0, 16'hFF00, -15'sd14564, 0));
    cmd_backlog.push_back(fixed_cmd(FUNC_TICK, 0, 0, 0, 0, 0, 16'h0800));
    cmd_backlog.push_back(fixed_cmd(2'd3, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF,
                                    16'hFFFF, 15'h7FFF, 16'hFFFF));
    cmd_backlog.push_back(fixed_cmd(FUNC_START, 32'hFFFFFFFF, 0, 16'hFFFF, 0, 0, 0));
    cmd_backlog.push_back(fixed_cmd(FUNC_TICK, 0, 0, 0, 0, 0, 16'hFFFF));
    wait_drained();

    // Sweep the wheelbase through its reset value, its extremes, zero included, and a random value.
    wb_plan[0] = WB_RESET;
    wb_plan[1] = 16'd1;
    wb_plan[2] = 16'hFFFF;
    wb_plan[3] = 16'd0;
    wb_plan[4] = 16'($urandom_range(1, 65535));
    for (int ph = 0; ph < 5; ph++) begin
      write_wheelbase(wb_plan[ph]);
      no_idle = (ph == 2);
      random_drive(205);
      wait_drained();
    end

    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
